// ----- hdl/swc_pkg.sv -----
// Shared types and constants for the separative work calculator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package swc_pkg;

  // Mass format of product, feed, tails and separative work
  localparam int MASS_W = 48;
  localparam int MASS_HALF_W = MASS_W / 2;
  localparam logic [MASS_W-1:0] MASS_MAX = {1'b0, {(MASS_W-1){1'b1}}};
  localparam logic [MASS_W-1:0] MASS_MIN = {1'b1, {(MASS_W-1){1'b0}}};

  // Logarithm unit: normalization by binary search, then one squaring per fraction bit
  localparam int NRM_W = 32;
  localparam int NRM_STEPS = 5;
  localparam int LOG_EXP_W = 5;
  localparam int LOG_FRAC_BITS = 28;
  localparam int LOG_W = LOG_EXP_W + LOG_FRAC_BITS;
  localparam int LOG_LAT = NRM_STEPS + LOG_FRAC_BITS;

  // Value function V(x) in Q.24
  localparam int VAL_FRAC_BITS = 24;
  localparam int VAL_W = 29;
  localparam int LN2_W = 30;
  localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
  localparam int LN_SHIFT = LOG_FRAC_BITS + LN2_W - VAL_FRAC_BITS;
  localparam int VAL_LAT = LOG_LAT + 3;

  // Wide multiplier and restoring divider
  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = MASS_W + 1;

  // Result status codes
  localparam int STATUS_W = 2;
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ASSAY = 2'd1,
    ST_EQUAL     = 2'd2
  } status_t;

  // Output payload
  localparam int OUT_W = 3 * MASS_W + STATUS_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- hdl/swc_log.sv -----
// Pipelined base-2 logarithm, result Q.28, of an unsigned integer up to 32 bits.
// Depends on swc_pkg.
`default_nettype none

module swc_log
  import swc_pkg::*;
#(
  parameter int M_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [M_W-1:0]   m,
  output logic [LOG_W-1:0] log2_q
);

  logic [NRM_W-1:0]         nrm_y_r  [NRM_STEPS];
  logic [LOG_EXP_W-1:0]     nrm_lz_r [NRM_STEPS];
  logic [NRM_W-2:0]         sq_y_r   [LOG_FRAC_BITS];
  logic [LOG_FRAC_BITS-1:0] sq_f_r   [LOG_FRAC_BITS];
  logic [LOG_EXP_W-1:0]     sq_e_r   [LOG_FRAC_BITS];

  genvar k;

  // Normalize: shift left until the top bit is set, count the shift
  generate
    for (k = 0; k < NRM_STEPS; k++) begin : g_nrm
      localparam int SH = (NRM_W / 2) >> k;
      logic [NRM_W-1:0]     y_in;
      logic [NRM_W-1:0]     y_nxt;
      logic [LOG_EXP_W-1:0] lz_in;
      logic [LOG_EXP_W-1:0] lz_nxt;

      if (k == 0) begin : g_first
        assign y_in  = NRM_W'(m);
        assign lz_in = '0;
      end else begin : g_next
        assign y_in  = nrm_y_r[k-1];
        assign lz_in = nrm_lz_r[k-1];
      end

      always_comb begin
        if (y_in[NRM_W-1 -: SH] == '0) begin
          y_nxt  = y_in << SH;
          lz_nxt = lz_in + LOG_EXP_W'(SH);
        end else begin
          y_nxt  = y_in;
          lz_nxt = lz_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          nrm_y_r[k]  <= y_nxt;
          nrm_lz_r[k] <= lz_nxt;
        end
      end
    end

    // Fraction bits: square the Q1.30 mantissa, renormalize, emit one bit
    for (k = 0; k < LOG_FRAC_BITS; k++) begin : g_sq
      logic [NRM_W-2:0]         y_in;
      logic [NRM_W-2:0]         y_nxt;
      logic [LOG_FRAC_BITS-1:0] f_in;
      logic [LOG_FRAC_BITS-1:0] f_nxt;
      logic [LOG_EXP_W-1:0]     e_in;
      logic [2*NRM_W-3:0]       sq;
      logic [NRM_W-1:0]         t;

      if (k == 0) begin : g_first
        assign y_in = nrm_y_r[NRM_STEPS-1][NRM_W-1:1];
        assign f_in = '0;
        assign e_in = LOG_EXP_W'(NRM_W - 1) - nrm_lz_r[NRM_STEPS-1];
      end else begin : g_next
        assign y_in = sq_y_r[k-1];
        assign f_in = sq_f_r[k-1];
        assign e_in = sq_e_r[k-1];
      end

      always_comb begin
        sq    = (2*NRM_W-2)'(y_in) * (2*NRM_W-2)'(y_in);
        t     = sq[2*NRM_W-3:NRM_W-2];
        y_nxt = t[NRM_W-1] ? t[NRM_W-1:1] : t[NRM_W-2:0];
        f_nxt = {f_in[LOG_FRAC_BITS-2:0], t[NRM_W-1]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq_y_r[k] <= y_nxt;
          sq_f_r[k] <= f_nxt;
          sq_e_r[k] <= e_in;
        end
      end
    end
  endgenerate

  assign log2_q = {sq_e_r[LOG_FRAC_BITS-1], sq_f_r[LOG_FRAC_BITS-1]};

endmodule

`default_nettype wire

// ----- hdl/swc_value.sv -----
// Pipelined value function V(x) = |1-2x| * |ln((1-x)/x)|, Q.24, of one assay.
// Depends on swc_pkg and swc_log.
`default_nettype none

module swc_value
  import swc_pkg::*;
#(
  parameter int A_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [A_W-1:0]   a,
  output logic [VAL_W-1:0] val
);

  logic [A_W-1:0]   om;
  logic [A_W-1:0]   cmag;
  logic [LOG_W-1:0] lb;
  logic [LOG_W-1:0] la;
  logic [A_W-1:0]   cmag_r [LOG_LAT+2];
  logic [LOG_W-1:0] dmag_r;
  logic [LOG_W-1:0] dmag_nxt;
  logic [VAL_W-1:0] ln_r;
  logic [VAL_W-1:0] ln_nxt;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic [LOG_W+LN2_W-1:0] ln_prod;
  logic [A_W+VAL_W-1:0]   v_prod;

  // 1 - x, and |1 - 2x|, both below one in the assay format
  assign om   = '0 - a;
  assign cmag = a[A_W-1] ? {a[A_W-2:0], 1'b0} : ('0 - {a[A_W-2:0], 1'b0});

  swc_log #(.M_W(A_W)) u_log_om (.clk(clk), .en(en), .m(om), .log2_q(lb));
  swc_log #(.M_W(A_W)) u_log_a  (.clk(clk), .en(en), .m(a),  .log2_q(la));

  always_comb begin
    dmag_nxt = (lb >= la) ? (lb - la) : (la - lb);
    ln_prod  = (LOG_W+LN2_W)'(dmag_r) * (LOG_W+LN2_W)'(LN2_Q30);
    ln_nxt   = ln_prod[LN_SHIFT +: VAL_W];
    v_prod   = (A_W+VAL_W)'(cmag_r[LOG_LAT+1]) * (A_W+VAL_W)'(ln_r);
    val_nxt  = v_prod[A_W +: VAL_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmag_r[0] <= cmag;
      for (int i = 1; i < LOG_LAT + 2; i++) begin
        cmag_r[i] <= cmag_r[i-1];
      end
      dmag_r <= dmag_nxt;
      ln_r   <= ln_nxt;
      val_r  <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

// ----- hdl/swc_mulwide.sv -----
// Two-stage 48 by B_W bit multiplier built from four registered partial products.
// Depends on swc_pkg.
`default_nettype none

module swc_mulwide
  import swc_pkg::*;
#(
  parameter int B_W = 24
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MASS_W-1:0]     p,
  input  logic [B_W-1:0]        b,
  output logic [MASS_W+B_W-1:0] prod
);

  localparam int PW = MASS_W + B_W;
  localparam int HW = MASS_HALF_W;
  localparam int BL = (B_W + 1) / 2;
  localparam int BH = B_W - BL;

  logic [HW+BL-1:0] pp_ll_r;
  logic [HW+BH-1:0] pp_lh_r;
  logic [HW+BL-1:0] pp_hl_r;
  logic [HW+BH-1:0] pp_hh_r;
  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    prod_nxt;

  assign prod_nxt = PW'(pp_ll_r) + (PW'(pp_lh_r) << BL) + (PW'(pp_hl_r) << HW)
                  + (PW'(pp_hh_r) << (HW + BL));

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= (HW+BL)'(p[HW-1:0])      * (HW+BL)'(b[BL-1:0]);
      pp_lh_r <= (HW+BH)'(p[HW-1:0])      * (HW+BH)'(b[B_W-1:BL]);
      pp_hl_r <= (HW+BL)'(p[MASS_W-1:HW]) * (HW+BL)'(b[BL-1:0]);
      pp_hh_r <= (HW+BH)'(p[MASS_W-1:HW]) * (HW+BH)'(b[B_W-1:BL]);
      prod_r  <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- hdl/swc_div.sv -----
// Pipelined restoring divider: 48-bit quotient of num / den with overflow flag.
// Depends on swc_pkg; needs NUM_W - 48 >= DEN_W.
`default_nettype none

module swc_div
  import swc_pkg::*;
#(
  parameter int NUM_W = 72,
  parameter int DEN_W = 24
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [MASS_W-1:0] q,
  output logic              ovf
);

  localparam int TOP_W = NUM_W - MASS_W;

  logic [DEN_W-1:0]  d_r   [DIV_LAT];
  logic [DEN_W-1:0]  r_r   [DIV_LAT];
  logic [MASS_W-1:0] w_r   [DIV_LAT];
  logic              ovf_r [DIV_LAT];
  logic [TOP_W-1:0]  top;

  // Quotient does not fit 48 bits when the top part already reaches the divisor
  assign top = num[NUM_W-1:MASS_W];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= den;
      r_r[0]   <= top[DEN_W-1:0];
      w_r[0]   <= num[MASS_W-1:0];
      ovf_r[0] <= (top >= TOP_W'(den));
    end
  end

  genvar k;
  generate
    for (k = 1; k < DIV_LAT; k++) begin : g_step
      logic [DEN_W:0]    t;
      logic [DEN_W:0]    t_sub;
      logic              ge;
      logic [DEN_W-1:0]  r_nxt;
      logic [MASS_W-1:0] w_nxt;

      // Shift in the next dividend bit, subtract when it fits, shift out a quotient bit
      always_comb begin
        t     = {r_r[k-1], w_r[k-1][MASS_W-1]};
        t_sub = t - {1'b0, d_r[k-1]};
        ge    = (t >= {1'b0, d_r[k-1]});
        r_nxt = ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
        w_nxt = {w_r[k-1][MASS_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          d_r[k]   <= d_r[k-1];
          r_r[k]   <= r_nxt;
          w_r[k]   <= w_nxt;
          ovf_r[k] <= ovf_r[k-1];
        end
      end
    end
  endgenerate

  assign q   = w_r[DIV_LAT-1];
  assign ovf = ovf_r[DIV_LAT-1];

endmodule

`default_nettype wire

// ----- hdl/separative_work_calculator_top.sv -----
// Separative work calculator top level: feed, tails and SWU for each stream transfer.
// The pipeline depth is set mainly by the 28 squaring steps of the logarithm units and the
// 48 steps of the restoring dividers. Throughput: one item per cycle unless stalled.
// The pipeline holds as a whole whenever the output register is full and not taken.
// Reset (rst_n low, synchronous) clears only the valid bits; data registers are not reset.
`default_nettype none

module separative_work_calculator_top
  import swc_pkg::*;
#(
  parameter int ASSAY_FRAC_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, from bit 0: product_mass[47:0], feed_assay, product_assay, tails_assay
  // (each ASSAY_FRAC_BITS+1 bits), zero padded to whole bytes
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((MASS_W + 3*(ASSAY_FRAC_BITS+1) + 7) / 8) * 8 - 1:0] in_tdata,
  // out_tdata, from bit 0: feed_mass[47:0], tails_mass[47:0], swu[47:0], status[1:0],
  // zero padded to whole bytes
  output logic out_tvalid,
  input  logic out_tready,
  output logic [OUT_TW-1:0] out_tdata
);

  localparam int A    = ASSAY_FRAC_BITS;
  localparam int AW   = A + 1;          // assay field width
  localparam int DW   = A + 2;          // signed assay difference
  localparam int NW   = A + 32;         // signed SWU numerator
  localparam int LAT  = 1 + VAL_LAT + 3 + MUL_LAT + DIV_LAT + 1;
  localparam int STAT_LSB = 3 * MASS_W;

  typedef struct packed {
    logic [MASS_W-1:0] p;
    logic [DW-1:0]     dft;
    logic [DW-1:0]     dpt;
    logic [DW-1:0]     dpf;
    status_t           status;
  } side1_t;

  typedef struct packed {
    logic [MASS_W-1:0] p;
    logic [A-1:0]      dftm;
    logic [A-1:0]      dptm;
    logic [A-1:0]      dpfm;
    logic              dneg;
    logic              fneg;
    logic              tneg;
    status_t           status;
  } side2_t;

  typedef struct packed {
    logic [A-1:0] dftm;
    logic         fneg;
    logic         tneg;
    logic         sneg;
    status_t      status;
  } side3_t;

  // ---------------------------------------------------------------------------
  // Flow control: one enable for the whole pipeline, valid bits travel alongside
  // ---------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: unpack, range checks, assay differences
  // ---------------------------------------------------------------------------
  logic [MASS_W-1:0] in_p;
  logic [AW-1:0]     in_xf;
  logic [AW-1:0]     in_xp;
  logic [AW-1:0]     in_xt;
  logic              bad;
  side1_t            s0_nxt;
  side1_t            s0_side_r;
  logic [A-1:0]      s0_xf_r;
  logic [A-1:0]      s0_xp_r;
  logic [A-1:0]      s0_xt_r;

  assign in_p  = in_tdata[MASS_W-1:0];
  assign in_xf = in_tdata[MASS_W +: AW];
  assign in_xp = in_tdata[MASS_W+AW +: AW];
  assign in_xt = in_tdata[MASS_W+2*AW +: AW];

  // An assay of zero, or with the 1.0 bit set, is out of range
  assign bad = (in_xf == '0) || (in_xp == '0) || (in_xt == '0)
            || in_xf[A] || in_xp[A] || in_xt[A];

  always_comb begin
    s0_nxt.p   = in_p;
    s0_nxt.dft = DW'(in_xf) - DW'(in_xt);
    s0_nxt.dpt = DW'(in_xp) - DW'(in_xt);
    s0_nxt.dpf = DW'(in_xp) - DW'(in_xf);
    if (bad) begin
      s0_nxt.status = ST_BAD_ASSAY;
    end else if (in_xf == in_xt) begin
      s0_nxt.status = ST_EQUAL;
    end else begin
      s0_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side_r <= s0_nxt;
      s0_xf_r   <= in_xf[A-1:0];
      s0_xp_r   <= in_xp[A-1:0];
      s0_xt_r   <= in_xt[A-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Value function of the three assays; hold the side data alongside
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] v_f;
  logic [VAL_W-1:0] v_p;
  logic [VAL_W-1:0] v_t;
  side1_t           d1_r [VAL_LAT];
  side1_t           d1o;

  swc_value #(.A_W(A)) u_val_f (.clk(clk), .en(en), .a(s0_xf_r), .val(v_f));
  swc_value #(.A_W(A)) u_val_p (.clk(clk), .en(en), .a(s0_xp_r), .val(v_p));
  swc_value #(.A_W(A)) u_val_t (.clk(clk), .en(en), .a(s0_xt_r), .val(v_t));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= s0_side_r;
      for (int i = 1; i < VAL_LAT; i++) begin
        d1_r[i] <= d1_r[i-1];
      end
    end
  end

  assign d1o = d1_r[VAL_LAT-1];

  // ---------------------------------------------------------------------------
  // N1..N3: SWU numerator V(xp)*dft + dpf*V(xt) - dpt*V(xf), then its magnitude
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] pp_r [3];
  logic signed [NW-1:0] n_r;
  logic [NW-2:0]        nmag_r;
  logic                 nneg_r;
  logic [NW-1:0]        n_neg;
  logic [DW-1:0]        dft_neg;
  logic [DW-1:0]        dpt_neg;
  logic [DW-1:0]        dpf_neg;
  side2_t               n1_nxt;
  side2_t               n_side_r [3];

  always_comb begin
    dft_neg = '0 - d1o.dft;
    dpt_neg = '0 - d1o.dpt;
    dpf_neg = '0 - d1o.dpf;
    n1_nxt.p      = d1o.p;
    n1_nxt.dftm   = d1o.dft[DW-1] ? dft_neg[A-1:0] : d1o.dft[A-1:0];
    n1_nxt.dptm   = d1o.dpt[DW-1] ? dpt_neg[A-1:0] : d1o.dpt[A-1:0];
    n1_nxt.dpfm   = d1o.dpf[DW-1] ? dpf_neg[A-1:0] : d1o.dpf[A-1:0];
    n1_nxt.dneg   = d1o.dft[DW-1];
    n1_nxt.fneg   = d1o.dpt[DW-1] ^ d1o.dft[DW-1];
    n1_nxt.tneg   = d1o.dpf[DW-1] ^ d1o.dft[DW-1];
    n1_nxt.status = d1o.status;
    n_neg         = '0 - n_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= NW'($signed({1'b0, v_p})) * NW'($signed(d1o.dft));
      pp_r[1] <= NW'($signed({1'b0, v_t})) * NW'($signed(d1o.dpf));
      pp_r[2] <= NW'($signed({1'b0, v_f})) * NW'($signed(d1o.dpt));
      n_r     <= pp_r[0] + pp_r[1] - pp_r[2];
      nmag_r  <= n_r[NW-1] ? n_neg[NW-2:0] : n_r[NW-2:0];
      nneg_r  <= n_r[NW-1];
      n_side_r[0] <= n1_nxt;
      n_side_r[1] <= n_side_r[0];
      n_side_r[2] <= n_side_r[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Full-width numerators and the three divisions
  // ---------------------------------------------------------------------------
  logic [MASS_W+A-1:0]    prod_f;
  logic [MASS_W+A-1:0]    prod_t;
  logic [MASS_W+NW-2:0]   prod_s;
  side3_t                 d2_r [MUL_LAT+DIV_LAT];
  side3_t                 d2_nxt;
  side3_t                 d2o;
  logic [MASS_W-1:0]      q_f;
  logic [MASS_W-1:0]      q_t;
  logic [MASS_W-1:0]      q_s;
  logic                   ovf_f;
  logic                   ovf_t;
  logic                   ovf_s;

  swc_mulwide #(.B_W(A)) u_mul_f (
    .clk(clk), .en(en), .p(n_side_r[2].p), .b(n_side_r[2].dptm), .prod(prod_f)
  );
  swc_mulwide #(.B_W(A)) u_mul_t (
    .clk(clk), .en(en), .p(n_side_r[2].p), .b(n_side_r[2].dpfm), .prod(prod_t)
  );
  swc_mulwide #(.B_W(NW-1)) u_mul_s (
    .clk(clk), .en(en), .p(n_side_r[2].p), .b(nmag_r), .prod(prod_s)
  );

  always_comb begin
    d2_nxt.dftm   = n_side_r[2].dftm;
    d2_nxt.fneg   = n_side_r[2].fneg;
    d2_nxt.tneg   = n_side_r[2].tneg;
    d2_nxt.sneg   = nneg_r ^ n_side_r[2].dneg;
    d2_nxt.status = n_side_r[2].status;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0] <= d2_nxt;
      for (int i = 1; i < MUL_LAT + DIV_LAT; i++) begin
        d2_r[i] <= d2_r[i-1];
      end
    end
  end

  swc_div #(.NUM_W(MASS_W+A), .DEN_W(A)) u_div_f (
    .clk(clk), .en(en), .num(prod_f), .den(d2_r[MUL_LAT-1].dftm), .q(q_f), .ovf(ovf_f)
  );
  swc_div #(.NUM_W(MASS_W+A), .DEN_W(A)) u_div_t (
    .clk(clk), .en(en), .num(prod_t), .den(d2_r[MUL_LAT-1].dftm), .q(q_t), .ovf(ovf_t)
  );
  // SWU divisor carries the value-function scale
  swc_div #(.NUM_W(MASS_W+NW-1), .DEN_W(A+VAL_FRAC_BITS)) u_div_s (
    .clk(clk), .en(en), .num(prod_s),
    .den({d2_r[MUL_LAT-1].dftm, {VAL_FRAC_BITS{1'b0}}}), .q(q_s), .ovf(ovf_s)
  );

  assign d2o = d2_r[MUL_LAT+DIV_LAT-1];

  // ---------------------------------------------------------------------------
  // Output register: apply sign, saturate, zero the masses on a bad-assay or equal-assay item
  // ---------------------------------------------------------------------------
  function automatic logic [MASS_W-1:0] to_mass(input logic [MASS_W-1:0] q,
                                                input logic ovf, input logic neg);
    logic [MASS_W-1:0] res;
    if (!neg || (q == '0 && !ovf)) begin
      res = (ovf || q[MASS_W-1]) ? MASS_MAX : q;
    end else begin
      res = (ovf || q > MASS_MIN) ? MASS_MIN : ('0 - q);
    end
    return res;
  endfunction

  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_data_nxt;

  always_comb begin
    if (d2o.status == ST_OK) begin
      out_data_nxt = {d2o.status, to_mass(q_s, ovf_s, d2o.sneg),
                      to_mass(q_t, ovf_t, d2o.tneg), to_mass(q_f, ovf_f, d2o.fneg)};
    end else begin
      out_data_nxt = {d2o.status, {(3*MASS_W){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = {{(OUT_TW-OUT_W){1'b0}}, out_data_r};

`ifndef SYNTHESIS
  // A rejected item never carries a nonzero mass
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STAT_LSB +: STATUS_W] != ST_OK)
      |-> (out_tdata[STAT_LSB-1:0] == '0))
    else $error("nonzero result on a rejected item");

  // Every input transfer lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item lost at pipeline entry");

  // A stall freezes every valid bit of the pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

// ----- tb/separative_work_calculator_checker.sv -----
// Scoreboard for the separative work calculator: watches both stream channels,
// predicts feed, tails and SWU per input transfer and compares each result.
// Depends on swc_pkg for the mass format, status codes and log/value constants.
`default_nettype none

module separative_work_calculator_checker
  import swc_pkg::*;
#(
  parameter int AB = 24,
  parameter int IN_TW = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_TW-1:0] out_tdata,
  output int                err_count,
  output int                pending,
  output int                results_seen
);

  typedef struct packed {
    logic [MASS_W-1:0] feed;
    logic [MASS_W-1:0] tails;
    logic [MASS_W-1:0] swu;
    status_t           status;
  } balance_t;

  balance_t balance_q[$];

  // log2 of m in [1, 2^32), Q.28, squaring kept in Q1.30
  function automatic logic [63:0] log2_q28(logic [63:0] m);
    int e;
    logic [63:0] y, f;
    e = 0;
    f = 0;
    while (e < 63 && (m >> (e + 1)) != 0) e++;
    y = (e <= 30) ? (m << (30 - e)) : (m >> (e - 30));
    for (int i = 0; i < LOG_FRAC_BITS; i++) begin
      y = (y * y) >> 30;
      f = f << 1;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        f = f | 64'd1;
      end
    end
    return (64'(e) << LOG_FRAC_BITS) | f;
  endfunction

  // V(a) = |1-2a| * |ln((1-a)/a)|, Q.24
  function automatic longint assay_value(logic [63:0] a);
    logic [63:0] one, lb, la, dmag, cmag;
    logic [127:0] ln24;
    one = 64'd1 << AB;
    lb = log2_q28(one - a);
    la = log2_q28(a);
    dmag = (lb >= la) ? lb - la : la - lb;
    ln24 = (128'(dmag) * 128'(LN2_Q30)) >> LN_SHIFT;
    cmag = (2 * a <= one) ? one - 2 * a : 2 * a - one;
    return longint'((128'(cmag) * ln24) >> AB);
  endfunction

  function automatic logic [MASS_W-1:0] saturate_mass(logic [127:0] mag, bit neg);
    if (!neg) return (mag > 128'(MASS_MAX)) ? MASS_MAX : mag[MASS_W-1:0];
    if (mag > 128'(MASS_MAX) + 1) mag = 128'(MASS_MAX) + 1;
    return -mag[MASS_W-1:0];
  endfunction

  function automatic balance_t predict_balance(logic [IN_TW-1:0] d);
    balance_t r;
    logic [63:0] p, xf, xp, xt, one;
    longint dft, dpt, dpf, n;
    logic [127:0] dftm, m, mag;
    bit dneg;
    one = 64'd1 << AB;
    p  = 64'(d[MASS_W-1:0]);
    xf = 64'(d[MASS_W +: AB+1]);
    xp = 64'(d[MASS_W + (AB+1) +: AB+1]);
    xt = 64'(d[MASS_W + 2*(AB+1) +: AB+1]);
    r = '{feed: '0, tails: '0, swu: '0, status: ST_OK};
    if (xf == 0 || xp == 0 || xt == 0 || xf >= one || xp >= one || xt >= one) begin
      r.status = ST_BAD_ASSAY;
      return r;
    end
    if (xf == xt) begin
      r.status = ST_EQUAL;
      return r;
    end
    dft = longint'(xf) - longint'(xt);
    dpt = longint'(xp) - longint'(xt);
    dpf = longint'(xp) - longint'(xf);
    dneg = dft < 0;
    dftm = 128'(dneg ? -dft : dft);

    mag = 128'(dpt < 0 ? -dpt : dpt);
    m = (128'(p) * mag) / dftm;
    r.feed = saturate_mass(m, ((dpt < 0) != dneg) && m != 0);

    mag = 128'(dpf < 0 ? -dpf : dpf);
    m = (128'(p) * mag) / dftm;
    r.tails = saturate_mass(m, ((dpf < 0) != dneg) && m != 0);

    n = assay_value(xp) * dft + dpf * assay_value(xt) - dpt * assay_value(xf);
    mag = 128'(n < 0 ? -n : n);
    m = (128'(p) * mag) / (dftm << VAL_FRAC_BITS);
    r.swu = saturate_mass(m, ((n < 0) != dneg) && m != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    balance_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) balance_q.push_back(predict_balance(in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got.feed   = out_tdata[0 +: MASS_W];
        got.tails  = out_tdata[MASS_W +: MASS_W];
        got.swu    = out_tdata[2*MASS_W +: MASS_W];
        got.status = status_t'(out_tdata[3*MASS_W +: STATUS_W]);
        if (balance_q.size() == 0) begin
          if (err_count < 10) $display("ERROR: unexpected result %h", out_tdata);
          err_count <= err_count + 1;
        end else begin
          want = balance_q.pop_front();
          if (want != got) begin
            if (err_count < 10)
              $display("ERROR: feed %h/%h tails %h/%h swu %h/%h status %0d/%0d (exp/got)",
                       want.feed, got.feed, want.tails, got.tails,
                       want.swu, got.swu, want.status, got.status);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end

  initial begin
    err_count = 0;
    results_seen = 0;
  end

  assign pending = balance_q.size();

endmodule

`default_nettype wire

// ----- tb/separative_work_calculator_top_test.sv -----
// Testbench top for the separative work calculator: clock, reset, stimulus and verdict.
// Depends on swc_pkg, separative_work_calculator_top and separative_work_calculator_checker.
`default_nettype none

module separative_work_calculator_top_test;
  import swc_pkg::*;

  localparam int AB = 24;
  localparam int IN_TW = ((MASS_W + 3*(AB+1) + 7) / 8) * 8;
  localparam int N_RANDOM = 1430;
  localparam int QUIET_TAIL = 150;      // final items sent with no idling on either side
  localparam int LIMIT = 300000;
  localparam logic [AB:0] ONE = 25'd1 << AB;
  localparam logic [AB:0] AMAX = {(AB+1){1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  int err_count, pending, results_seen;
  int cycles = 0;
  int sent = 0;
  bit quiet = 1'b0;     // set for the tail of the run: no idling
  bit held_off = 1'b0;  // the long receiver stall has happened

  always #5 clk = ~clk;

  separative_work_calculator_top #(.ASSAY_FRAC_BITS(AB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  separative_work_calculator_checker #(.AB(AB), .IN_TW(IN_TW)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .err_count(err_count), .pending(pending), .results_seen(results_seen)
  );

  // Hard stop on a hung pipeline
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer completes. An optional idle
  // burst precedes it; valid stays high between back-to-back items.
  task automatic send_item(logic [47:0] qty, logic [AB:0] xf, logic [AB:0] xp,
                           logic [AB:0] xt);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TW'({xt, xp, xf, qty});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [AB:0] good_assay();
    case ($urandom_range(0, 3))
      0: return (AB+1)'($urandom_range(1, 255));                      // very lean
      1: return ONE - (AB+1)'($urandom_range(1, 255));                // nearly pure
      default: return (AB+1)'($urandom_range(1, 32'(ONE) - 1));
    endcase
  endfunction

  function automatic logic [AB:0] bad_assay();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return ONE;
      default: return (AB+1)'($urandom_range(32'(ONE), 32'(AMAX)));
    endcase
  endfunction

  function automatic logic [47:0] rand_qty();
    logic [47:0] q;
    q = 48'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: q = q & 48'hFF_FFFF;          // small masses
      1: q = q & 48'hFFFF_FFFF;
      default: ;
    endcase
    return q;
  endfunction

  // Receiver: random stall bursts, one long hold-off so the pipeline fills
  // and backs up the input, then always ready in the quiet tail.
  initial begin
    int burst;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (!held_off && sent > 300) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 5);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        burst = $urandom_range(1, 12);
        out_tready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  initial begin
    logic [AB:0] xf, xp, xt;
    int kind;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: typical enrichment, field extremes, bad assays, equal feed/tails
    send_item(48'h0001_0000, 25'd119_364, 25'd838_861, 25'd41_943); // 0.711% / 5% / 0.25%
    send_item(48'hFFFF_FFFF_FFFF, 25'd119_364, 25'd838_861, 25'd41_943);
    send_item(48'h0, 25'd119_364, 25'd838_861, 25'd41_943);
    send_item(48'h1, 25'd1, ONE - 25'd1, 25'd2);
    send_item(48'hFFFF_FFFF_FFFF, 25'd2, ONE - 25'd1, 25'd1);   // saturates
    send_item(48'hFFFF_FFFF_FFFF, 25'd1, ONE - 25'd1, ONE - 25'd1 - 25'd1);
    send_item(48'h1234_5678_9ABC, ONE >> 1, ONE >> 2, ONE - 25'd1); // product below feed, tails above feed
    send_item(48'h8000_0000_0000, ONE >> 1, ONE >> 1, 25'd1);
    send_item(48'h0001_0000, 25'd0, 25'd838_861, 25'd41_943);
    send_item(48'h0001_0000, 25'd119_364, 25'd0, 25'd41_943);
    send_item(48'h0001_0000, 25'd119_364, 25'd838_861, 25'd0);
    send_item(48'h0001_0000, ONE, 25'd838_861, 25'd41_943);
    send_item(48'h0001_0000, 25'd119_364, ONE, 25'd41_943);
    send_item(48'h0001_0000, 25'd119_364, 25'd838_861, AMAX);
    send_item(48'hFFFF_FFFF_FFFF, AMAX, AMAX, AMAX);
    send_item(48'h0001_0000, 25'd119_364, 25'd838_861, 25'd119_364);
    send_item(48'hFFFF_FFFF_FFFF, ONE - 25'd1, 25'd1, ONE - 25'd1);
    send_item(48'h0001_0000, ONE >> 1, ONE >> 1, ONE >> 1);

    // Random: mostly well-formed assays, some bad or equal-feed cases
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      xf = good_assay();
      xp = good_assay();
      xt = good_assay();
      kind = $urandom_range(0, 19);
      if (kind == 0) xf = bad_assay();
      else if (kind == 1) xp = bad_assay();
      else if (kind == 2) xt = bad_assay();
      else if (kind == 3) xt = xf;
      else if (kind == 4) begin
        xf = (AB+1)'($urandom_range(0, 32'(AMAX)));
        xp = (AB+1)'($urandom_range(0, 32'(AMAX)));
        xt = (AB+1)'($urandom_range(0, 32'(AMAX)));
      end
      send_item(rand_qty(), xf, xp, xt);
    end
    in_tvalid <= 1'b0;

    // Drain, then allow for the pipeline depth
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d items (%0d results), incl. bad assays, equal feed/tails,",
             sent, results_seen);
    $display("saturating masses, random stalls and a long output hold-off.");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/swc_pkg.sv
hdl/swc_log.sv
hdl/swc_value.sv
hdl/swc_mulwide.sv
hdl/swc_div.sv
hdl/separative_work_calculator_top.sv
tb/separative_work_calculator_checker.sv
tb/separative_work_calculator_top_test.sv
